// File: src/lcd_4bit_nibble_sequencer_defines.svh
// Assertion macros for the LCD nibble sequencer checker.
// No dependencies; included by the checker file only.
`ifndef LCD_4BIT_NIBBLE_SEQUENCER_DEFINES_SVH
`define LCD_4BIT_NIBBLE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define LCDNS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcdns check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define LCDNS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcdns check failed");

`endif

// File: src/lcdns_pkg.sv
// Shared types and constants for the LCD nibble sequencer.
// No dependencies; used by every RTL module.
package lcdns_pkg;

    localparam int unsigned WAIT_W    = 13;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned INIT_LEN  = 14;
    localparam int unsigned STEP_W    = $clog2(INIT_LEN);
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW  = 1'd1;
    localparam logic [CFG_W-1:0]     PULSE_RESET    = 16'd1000;

    localparam logic [WAIT_W-1:0] WAIT_NONE = 13'd0;
    localparam logic [WAIT_W-1:0] WAIT_LONG = 13'd1500;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_CHAR  = 3'd1,
        ACT_CLEAR = 3'd2,
        ACT_HOME  = 3'd3,
        ACT_SHIFT = 3'd4,
        ACT_LINE2 = 3'd5
    } action_t;

    typedef enum logic {
        CMD_PAIR = 1'b0,
        CMD_INIT = 1'b1
    } cmd_kind_t;

    // One queued command: either the power-up run or a byte sent as two nibbles.
    typedef struct packed {
        cmd_kind_t         kind;
        logic              rs;
        logic [7:0]        data;
        logic [WAIT_W-1:0] wait_lo;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    localparam logic [3:0] INIT_NIB [INIT_LEN] = '{
        4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0,
        4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hC
    };
    localparam logic [WAIT_W-1:0] INIT_WAIT [INIT_LEN] = '{
        13'd4200, 13'd110, 13'd110, 13'd110, 13'd0, 13'd55, 13'd0,
        13'd55, 13'd0, 13'd1500, 13'd0, 13'd55, 13'd0, 13'd55
    };

endpackage

// File: src/lcdns_front.sv
// Front end: takes actions, tracks the UTF-8 lead flag, builds queue commands.
// Depends on lcdns_pkg.
module lcdns_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_action,
    input  logic [7:0]            s_char_byte,
    input  logic                  s_shift_right,
    input  logic                  q_full,
    output lcdns_pkg::push_t      push
);

    localparam logic [7:0] UTF8_LEAD = 8'd195;

    logic pending_reg;
    logic pending_next;
    logic accept;

    function automatic logic [7:0] remap(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'ha4, 8'h84: r = 8'hE1;
            8'hb6, 8'h96: r = 8'hEF;
            8'hbc, 8'h9c: r = 8'hF5;
            8'h9f:        r = 8'hE2;
            default:      r = 8'hFF;
        endcase
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        push.valid       = 1'b0;
        push.cmd.kind    = lcdns_pkg::CMD_PAIR;
        push.cmd.rs      = 1'b0;
        push.cmd.data    = 8'h00;
        push.cmd.wait_lo = lcdns_pkg::WAIT_NONE;
        pending_next     = pending_reg;
        case (lcdns_pkg::action_t'(s_action))
            lcdns_pkg::ACT_INIT: begin
                push.valid    = accept;
                push.cmd.kind = lcdns_pkg::CMD_INIT;
                pending_next  = 1'b0;
            end
            lcdns_pkg::ACT_CHAR: begin
                if (s_char_byte == UTF8_LEAD) begin
                    pending_next = 1'b1;
                end else begin
                    push.valid    = accept;
                    push.cmd.rs   = 1'b1;
                    push.cmd.data = pending_reg ? remap(s_char_byte) : s_char_byte;
                    pending_next  = 1'b0;
                end
            end
            lcdns_pkg::ACT_CLEAR: begin
                push.valid       = accept;
                push.cmd.data    = 8'h01;
                push.cmd.wait_lo = lcdns_pkg::WAIT_LONG;
                pending_next     = 1'b0;
            end
            lcdns_pkg::ACT_HOME: begin
                push.valid       = accept;
                push.cmd.data    = 8'h02;
                push.cmd.wait_lo = lcdns_pkg::WAIT_LONG;
                pending_next     = 1'b0;
            end
            lcdns_pkg::ACT_SHIFT: begin
                push.valid    = accept;
                push.cmd.data = s_shift_right ? 8'h1D : 8'h19;
                pending_next  = 1'b0;
            end
            lcdns_pkg::ACT_LINE2: begin
                push.valid    = accept;
                push.cmd.data = 8'hC0;
                pending_next  = 1'b0;
            end
            default: begin
                // undefined action: dropped, flag kept
                push.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (accept) begin
            pending_reg <= pending_next;
        end
    end

endmodule

// File: src/lcdns_queue.sv
// Two-entry command FIFO between front and back end.
// Depends on lcdns_pkg.
module lcdns_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lcdns_pkg::push_t      push,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output lcdns_pkg::cmd_t       head_cmd
);

    lcdns_pkg::cmd_t                   entries_reg [lcdns_pkg::QDEPTH];
    logic [lcdns_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [lcdns_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [lcdns_pkg::QCNT_W-1:0]      count_reg;
    logic [lcdns_pkg::QCNT_W-1:0]      count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full       = (count_reg == lcdns_pkg::QCNT_W'(lcdns_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

// File: src/lcdns_back.sv
// Back end: steps the head command into nibble transactions on the output register.
// Depends on lcdns_pkg.
module lcdns_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  lcdns_pkg::cmd_t                     head_cmd,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_reg_select,
    output logic [3:0]                          m_nibble,
    output logic [lcdns_pkg::WAIT_W-1:0]        m_extra_wait_us,
    output logic                                m_last
);

    localparam logic [lcdns_pkg::STEP_W-1:0] INIT_END =
        lcdns_pkg::STEP_W'(lcdns_pkg::INIT_LEN - 1);

    logic [lcdns_pkg::STEP_W-1:0]  step_reg;
    logic                          valid_reg;
    logic                          rs_reg;
    logic [3:0]                    nib_reg;
    logic [lcdns_pkg::WAIT_W-1:0]  wait_reg;
    logic                          last_reg;

    logic                          load;
    logic [3:0]                    nib_cur;
    logic [lcdns_pkg::WAIT_W-1:0]  wait_cur;
    logic                          last_cur;

    always_comb begin
        if (head_cmd.kind == lcdns_pkg::CMD_INIT) begin
            nib_cur  = lcdns_pkg::INIT_NIB[step_reg];
            wait_cur = lcdns_pkg::INIT_WAIT[step_reg];
            last_cur = (step_reg == INIT_END);
        end else begin
            nib_cur  = step_reg[0] ? head_cmd.data[3:0] : head_cmd.data[7:4];
            wait_cur = step_reg[0] ? head_cmd.wait_lo : lcdns_pkg::WAIT_NONE;
            last_cur = step_reg[0];
        end
    end

    assign load = head_valid && (!valid_reg || m_ready);
    assign pop  = load && last_cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            step_reg  <= last_cur ? '0 : step_reg + 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rs_reg   <= head_cmd.rs;
            nib_reg  <= nib_cur;
            wait_reg <= wait_cur;
            last_reg <= last_cur;
        end
    end

    assign m_valid         = valid_reg;
    assign m_reg_select    = rs_reg;
    assign m_nibble        = nib_reg;
    assign m_extra_wait_us = wait_reg;
    assign m_last          = last_reg;

endmodule

// File: src/lcd_4bit_nibble_sequencer.sv
// An accepted input is written into the command queue; the back end then loads the head
// command into its single output register. Throughput: one nibble per cycle while a
// command is queued and m_ready allows; a character or command is two nibbles, init 14.
// s_ready drops only while the two-entry command queue is full.
// Reset (aresetn low, synchronous): clears the UTF-8 lead flag, the command queue and
// the output valid; pulse_high_us and pulse_low_us return to 1000.
module lcd_4bit_nibble_sequencer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [lcdns_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcdns_pkg::CFG_W-1:0]           cfg_wdata,
    // action input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_action,
    input  logic [7:0]                            s_char_byte,
    input  logic                                  s_shift_right,
    // nibble output channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_reg_select,
    output logic [3:0]                            m_nibble,
    output logic [lcdns_pkg::WAIT_W-1:0]          m_extra_wait_us,
    output logic                                  m_last
);

    // Pulse timing is held here for the enable pulse generator downstream;
    // it does not alter any nibble transaction.
    logic [lcdns_pkg::CFG_W-1:0] pulse_high_us_reg;
    logic [lcdns_pkg::CFG_W-1:0] pulse_low_us_reg;

    lcdns_pkg::push_t push;
    lcdns_pkg::cmd_t  head_cmd;
    logic             q_full;
    logic             head_valid;
    logic             pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_high_us_reg <= lcdns_pkg::PULSE_RESET;
            pulse_low_us_reg  <= lcdns_pkg::PULSE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lcdns_pkg::CFG_PULSE_HIGH: pulse_high_us_reg <= cfg_wdata;
                lcdns_pkg::CFG_PULSE_LOW:  pulse_low_us_reg  <= cfg_wdata;
                default: begin
                    pulse_high_us_reg <= pulse_high_us_reg;
                end
            endcase
        end
    end

    // Front: classifies each action transaction and pushes a command; the
    // UTF-8 lead byte and undefined actions push nothing.
    lcdns_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_char_byte   (s_char_byte),
        .s_shift_right (s_shift_right),
        .q_full        (q_full),
        .push          (push)
    );

    // Two-deep command queue decouples input stalls from output stalls.
    lcdns_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: walks the head command nibble by nibble into the output register.
    lcdns_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reg_select    (m_reg_select),
        .m_nibble        (m_nibble),
        .m_extra_wait_us (m_extra_wait_us),
        .m_last          (m_last)
    );

endmodule

// File: src/lcdns_checker.sv
// Port-level checks for the LCD nibble sequencer, bound to the top level.
// Depends on lcdns_pkg and lcd_4bit_nibble_sequencer_defines.svh.
`include "lcd_4bit_nibble_sequencer_defines.svh"

module lcdns_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_reg_select,
    input logic [3:0]                      m_nibble,
    input logic [lcdns_pkg::WAIT_W-1:0]    m_extra_wait_us,
    input logic                            m_last
);

    // data nibbles never carry an extra wait
    `LCDNS_ASSERT_NOW(a_data_no_wait, m_valid && m_reg_select, m_extra_wait_us == '0)

    // longest wait is the power-up one
    `LCDNS_ASSERT_NOW(a_wait_bound, m_valid, m_extra_wait_us <= 13'd4200)

    // high data nibble is followed at once by its low nibble, marked last
    `LCDNS_ASSERT_NEXT(a_char_pair, m_valid && m_ready && m_reg_select && !m_last, m_valid && m_reg_select && m_last)

    // stalled transaction holds
    `LCDNS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_nibble) && $stable(m_last) && $stable(m_extra_wait_us))

endmodule

bind lcd_4bit_nibble_sequencer lcdns_checker u_lcdns_checker (.*);

// File: tb/sv/lcd_4bit_nibble_sequencer_test.sv
// Self-checking testbench for lcd_4bit_nibble_sequencer: directed and random actions,
// checked nibble by nibble against an in-bench model of the HD44780 4-bit write sequences.
// Depends on lcdns_pkg and the lcd_4bit_nibble_sequencer RTL only.
module lcd_4bit_nibble_sequencer_test;

    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 200000;
    // drain after the last expected nibble, so a silent item has surely been consumed
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    // codes the block must ignore
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam logic [7:0] UTF8_LEAD_BYTE = 8'd195;
    localparam logic [7:0] UNMAPPED_CHAR  = 8'hFF;
    localparam logic [7:0] UMLAUT_IN  [7] = '{8'hA4, 8'hB6, 8'hBC, 8'h84, 8'h96, 8'h9C, 8'h9F};
    localparam logic [7:0] UMLAUT_OUT [7] = '{8'hE1, 8'hEF, 8'hF5, 8'hE1, 8'hEF, 8'hF5, 8'hE2};

    // power-up run: nibble and extra wait per step
    localparam logic [3:0] PWRUP_NIB [14] = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0,
                                              4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hC};
    localparam logic [lcdns_pkg::WAIT_W-1:0] PWRUP_WAIT [14] = '{
        13'd4200, 13'd110, 13'd110, 13'd110, 13'd0, 13'd55, 13'd0, 13'd55, 13'd0,
        13'd1500, 13'd0, 13'd55, 13'd0, 13'd55};
    localparam logic [lcdns_pkg::WAIT_W-1:0] CMD_WAIT_LONG = 13'd1500;
    localparam logic [lcdns_pkg::WAIT_W-1:0] NO_WAIT       = 13'd0;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_byte;
        logic       shift_right;
    } lcd_action_t;

    typedef struct packed {
        logic                         rs;
        logic [3:0]                   nib;
        logic [lcdns_pkg::WAIT_W-1:0] wait_us;
        logic                         last;
    } nibble_t;

    // DUT ports; the inputs are known from time zero
    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [lcdns_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [lcdns_pkg::CFG_W-1:0]     cfg_wdata     = '0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [2:0]                      s_action      = '0;
    logic [7:0]                      s_char_byte   = '0;
    logic                            s_shift_right = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic                            m_reg_select;
    logic [3:0]                      m_nibble;
    logic [lcdns_pkg::WAIT_W-1:0]    m_extra_wait_us;
    logic                            m_last;

    // stimulus and prediction state
    lcd_action_t pending_actions[$];
    nibble_t     expected_nibbles[$];
    lcd_action_t cur_action;
    logic        lead_pending;        // bench copy of the UTF-8 lead flag
    logic [lcdns_pkg::CFG_W-1:0] pulse_high_shadow = lcdns_pkg::PULSE_RESET;
    logic [lcdns_pkg::CFG_W-1:0] pulse_low_shadow  = lcdns_pkg::PULSE_RESET;

    int queued_count    = 0;
    int accepted_count  = 0;
    int nibbles_checked = 0;
    int pwrup_runs      = 0;
    int umlaut_remaps   = 0;
    int cfg_writes      = 0;
    int error_count     = 0;
    int stall_requests  = 0;

    lcd_4bit_nibble_sequencer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_byte     (s_char_byte),
        .s_shift_right   (s_shift_right),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reg_select    (m_reg_select),
        .m_nibble        (m_nibble),
        .m_extra_wait_us (m_extra_wait_us),
        .m_last          (m_last)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // hard stop in case the block hangs or drops a transaction
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [7:0] umlaut_remap(input logic [7:0] b);
        for (int i = 0; i < 7; i++)
            if (UMLAUT_IN[i] == b) return UMLAUT_OUT[i];
        return UNMAPPED_CHAR;
    endfunction

    // a byte goes out as high nibble then low nibble; only the low one may carry a wait
    function automatic void expect_byte(input logic rs, input logic [7:0] b,
                                        input logic [lcdns_pkg::WAIT_W-1:0] wait_lo);
        expected_nibbles.push_back('{rs, b[7:4], NO_WAIT, 1'b0});
        expected_nibbles.push_back('{rs, b[3:0], wait_lo, 1'b1});
    endfunction

    function automatic void predict_nibbles(input lcd_action_t a);
        logic [7:0] b;
        b = a.char_byte;
        case (a.action)
            lcdns_pkg::ACT_INIT: begin
                for (int i = 0; i < 14; i++)
                    expected_nibbles.push_back('{1'b0, PWRUP_NIB[i], PWRUP_WAIT[i], i == 13});
                lead_pending = 1'b0;
                pwrup_runs++;
            end
            lcdns_pkg::ACT_CHAR: begin
                if (b == UTF8_LEAD_BYTE) begin
                    // lead byte: nothing on the bus, flag armed (again)
                    lead_pending = 1'b1;
                end else begin
                    if (lead_pending) begin
                        b = umlaut_remap(b);
                        lead_pending = 1'b0;
                        umlaut_remaps++;
                    end
                    expect_byte(1'b1, b, NO_WAIT);
                end
            end
            lcdns_pkg::ACT_CLEAR: begin
                expect_byte(1'b0, 8'h01, CMD_WAIT_LONG);
                lead_pending = 1'b0;
            end
            lcdns_pkg::ACT_HOME: begin
                expect_byte(1'b0, 8'h02, CMD_WAIT_LONG);
                lead_pending = 1'b0;
            end
            lcdns_pkg::ACT_SHIFT: begin
                expect_byte(1'b0, a.shift_right ? 8'h1D : 8'h19, NO_WAIT);
                lead_pending = 1'b0;
            end
            lcdns_pkg::ACT_LINE2: begin
                expect_byte(1'b0, 8'hC0, NO_WAIT);
                lead_pending = 1'b0;
            end
            default: ; // undefined codes: no output, flag untouched
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them.
    // Prediction runs at the edge where the input transaction completes.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : action_driver
        logic took;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            lead_pending = 1'b0;
            burst_left   = 0;
            gap_left     = 0;
        end else begin
            took = s_valid && (s_ready === 1'b1);
            if (took) begin
                predict_nibbles(cur_action);
                accepted_count++;
            end
            if (s_valid && !took) begin
                // offered but not taken: hold valid and payload
            end else if (gap_left != 0 || pending_actions.size() == 0) begin
                if (gap_left != 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                if (burst_left == 0) burst_left = $urandom_range(1, 16);
                cur_action    = pending_actions.pop_front();
                s_action      <= cur_action.action;
                s_char_byte   <= cur_action.char_byte;
                s_shift_right <= cur_action.shift_right;
                s_valid       <= 1'b1;
                burst_left--;
                // a quarter of bursts run straight into the next one
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern changes per segment; a requested hold-off
    // drops ready until its HOLD_CYCLES countdown ends, so the block backs up into s_ready.
    // ------------------------------------------------------------------
    int stall_served = 0;
    int hold_left    = 0;
    int seg_left     = 0;
    int ready_mode   = 0;
    int phase_ctr    = 0;

    always @(posedge aclk) begin : nibble_receiver
        if (!aresetn) begin
            m_ready  <= 1'b0;
            seg_left = 0;
        end else if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left    = HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(10, 80);
                ready_mode = $urandom_range(0, 3);
            end
            seg_left--;
            phase_ctr++;
            case (ready_mode)
                0:       m_ready <= 1'b1;                            // no stalls
                1:       m_ready <= 1'($urandom_range(0, 1));        // coin flip
                2:       m_ready <= (phase_ctr % 4) == 0;            // one in four
                default: m_ready <= $urandom_range(0, 7) != 0;       // mostly ready
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every output transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : nibble_monitor
        nibble_t got;
        nibble_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = {m_reg_select, m_nibble, m_extra_wait_us, m_last};
            if (expected_nibbles.size() == 0) begin
                report_mismatch($sformatf("unexpected nibble rs=%b nib=%h wait=%0d last=%b",
                                          got.rs, got.nib, got.wait_us, got.last));
            end else begin
                want = expected_nibbles.pop_front();
                nibbles_checked++;
                if (got !== want)
                    report_mismatch($sformatf(
                        {"nibble #%0d: got rs=%b nib=%h wait=%0d last=%b, ",
                         "want rs=%b nib=%h wait=%0d last=%b"},
                        nibbles_checked, got.rs, got.nib, got.wait_us, got.last,
                        want.rs, want.nib, want.wait_us, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_action(input logic [2:0] act, input logic [7:0] b, input logic right);
        pending_actions.push_back('{act, b, right});
        queued_count++;
    endtask

    // idle = every item taken, every nibble seen, plus a drain for silent items
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_nibbles.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_pulse_reg(input logic [lcdns_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [lcdns_pkg::CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        // the pulse registers only feed timing, never the nibble stream
        if (idx == lcdns_pkg::CFG_PULSE_HIGH) pulse_high_shadow = val;
        else                                  pulse_low_shadow  = val;
        cfg_writes++;
    endtask

    // mostly characters and well-formed lead/continuation pairs, some noise
    task automatic queue_random_actions(input int n);
        int counted;
        int r;
        logic [7:0] cont;
        counted = 0;
        while (counted < n) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'($urandom_range(0, 1)));
                // an undefined code between lead and continuation must not drop the flag
                if ($urandom_range(0, 9) == 0)
                    queue_action($urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7, 8'($urandom),
                                 1'($urandom_range(0, 1)));
                r = $urandom_range(0, 99);
                if (r < 75)      cont = UMLAUT_IN[$urandom_range(0, 6)];
                else if (r < 90) cont = 8'($urandom);
                else             cont = UTF8_LEAD_BYTE;
                if (r < 95)
                    queue_action(lcdns_pkg::ACT_CHAR, cont, 1'($urandom_range(0, 1)));
                else // broken pair: a command in place of the continuation
                    queue_action(3'($urandom_range(lcdns_pkg::ACT_CLEAR, lcdns_pkg::ACT_LINE2)),
                                 8'($urandom), 1'($urandom_range(0, 1)));
                counted++;
            end else if (r < 60) begin
                queue_action(lcdns_pkg::ACT_CHAR, 8'($urandom), 1'($urandom_range(0, 1)));
                counted++;
            end else if (r < 65) begin
                queue_action(lcdns_pkg::ACT_INIT, 8'($urandom), 1'($urandom_range(0, 1)));
                counted++;
            end else if (r < 95) begin
                queue_action(3'($urandom_range(lcdns_pkg::ACT_CLEAR, lcdns_pkg::ACT_LINE2)),
                             8'($urandom), 1'($urandom_range(0, 1)));
                counted++;
            end else begin
                queue_action($urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7, 8'($urandom),
                             1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, pulse registers at their reset values
        queue_action(lcdns_pkg::ACT_INIT,  8'h00, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR,  8'h00, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR,  8'hFF, 1'b1);
        queue_action(lcdns_pkg::ACT_SHIFT, 8'h00, 1'b0);
        queue_action(lcdns_pkg::ACT_SHIFT, 8'hFF, 1'b1);
        queue_action(lcdns_pkg::ACT_CLEAR, 8'h5A, 1'b0);
        queue_action(lcdns_pkg::ACT_HOME,  8'hA5, 1'b1);
        queue_action(lcdns_pkg::ACT_LINE2, 8'h3C, 1'b0);
        // plain umlaut pair
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR, 8'hA4, 1'b0);
        // repeated lead keeps the flag armed
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b1);
        queue_action(lcdns_pkg::ACT_CHAR, 8'hB6, 1'b0);
        // undefined code between lead and continuation is ignored
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b0);
        queue_action(ACT_RSVD6, 8'hFF, 1'b1);
        queue_action(lcdns_pkg::ACT_CHAR, 8'h9F, 1'b0);
        // continuation not in the umlaut set maps to the block glyph
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR, 8'h41, 1'b0);
        // a command clears the flag, so the next byte passes unchanged
        queue_action(lcdns_pkg::ACT_CHAR, UTF8_LEAD_BYTE, 1'b0);
        queue_action(lcdns_pkg::ACT_HOME, 8'h00, 1'b0);
        queue_action(lcdns_pkg::ACT_CHAR, 8'hBC, 1'b0);
        queue_action(ACT_RSVD7, 8'h00, 1'b0);
        wait_idle();

        // extremes of the pulse registers
        write_pulse_reg(lcdns_pkg::CFG_PULSE_HIGH, 16'h0000);
        write_pulse_reg(lcdns_pkg::CFG_PULSE_LOW,  16'hFFFF);
        queue_random_actions(55);
        wait_idle();

        // swapped extremes, with a long receiver hold-off so the input backs up
        write_pulse_reg(lcdns_pkg::CFG_PULSE_HIGH, 16'hFFFF);
        write_pulse_reg(lcdns_pkg::CFG_PULSE_LOW,  16'h0000);
        stall_requests++;
        queue_random_actions(55);
        wait_idle();

        write_pulse_reg(lcdns_pkg::CFG_PULSE_HIGH, 16'($urandom));
        write_pulse_reg(lcdns_pkg::CFG_PULSE_LOW,  16'($urandom));
        queue_random_actions(40);
        wait_idle();

        // anything still expected here was never produced
        while (expected_nibbles.size() != 0) begin
            report_mismatch("expected nibble never arrived");
            void'(expected_nibbles.pop_front());
        end

        $display("Covered %0d actions: %0d power-up runs, %0d UTF-8 remaps, %0d nibbles checked",
                 accepted_count, pwrup_runs, umlaut_remaps, nibbles_checked);
        $display("Pulse registers written %0d times (last high=%0d low=%0d), one long hold-off",
                 cfg_writes, pulse_high_shadow, pulse_low_shadow);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
